// ===== hdl/srde_pkg.sv =====
// Shared types and constants for the signed radix digit emitter.
`timescale 1ns / 1ps

package srde_pkg;

    // Sizing defaults
    localparam int VALUE_BITS_DEF = 32;
    localparam int ALPHABET_MAX   = 16;
    localparam int ALPHA_BYTES    = 16;
    localparam int RADIX_W        = 5;
    localparam int DIGIT_W        = 4;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIX_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_FIRST = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_SECOND = 2'd2;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CTRL_LO    = 8'd9;
    localparam logic [7:0] CTRL_HI    = 8'd13;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_PUSH,
        ST_SIGN,
        ST_EMIT,
        ST_BAD
    } state_t;

    // True for a byte that may not appear in the digit alphabet
    function automatic logic byte_forbidden(input logic [7:0] b);
        logic hit;
        hit = (b == CHAR_NUL) || (b == CHAR_SPACE) || (b == CHAR_PLUS) ||
              (b == CHAR_MINUS) || (b inside {[CTRL_LO:CTRL_HI]});
        return hit;
    endfunction

endpackage

// ===== hdl/signed_radix_digit_emitter.sv =====
// Top level: signed integer to text in a configurable radix, MSD first.
`timescale 1ns / 1ps

//  channel   ports                                      transfer when
//  input     start, busy, value                         start && !busy
//  result    result_strobe, character, last,            result_strobe
//            bad_alphabet
//  config    cfg_wen, cfg_index, cfg_data               cfg_wen
//
//  One item: alphabet check of up to radix_size bytes, then each digit in the
//  restoring divider (one quotient bit a cycle) and a push to the digit
//  stack, then an optional minus sign and the digit characters out.
//  Reset clears the sequencer and configuration registers.
//  Results are strobed for one cycle each; the receiver cannot stall.
//  busy stays high until the last character has been strobed.

module signed_radix_digit_emitter #(
    parameter int VALUE_BITS = srde_pkg::VALUE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [31:0]                 value,
    output logic                               result_strobe,
    output logic [7:0]                         character,
    output logic                               last,
    output logic                               bad_alphabet,
    input  logic                               cfg_wen,
    input  logic [srde_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [srde_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int IDX_W  = $clog2(VALUE_BITS);
    localparam int STEP_W = $clog2(VALUE_BITS);
    localparam int RW     = srde_pkg::RADIX_W;
    localparam int DW     = srde_pkg::DIGIT_W;

    // Configuration registers
    logic [RW-1:0]                      radix_size_reg;
    logic [srde_pkg::CFG_DATA_W-1:0]    alpha_first_reg;
    logic [srde_pkg::CFG_DATA_W-1:0]    alpha_second_reg;
    logic [8*srde_pkg::ALPHA_BYTES-1:0] alphabet;

    // Sequencer and datapath
    srde_pkg::state_t   state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [DW-1:0]      rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DW-1:0]      chk_idx_reg, chk_idx_next;
    logic               neg_reg, neg_next;
    logic [DW-1:0]      stack_mem [VALUE_BITS];

    logic               accept;
    logic               size_bad;
    logic [7:0]         chk_byte;
    logic               dup_hit;
    logic               chk_bad;
    logic               chk_last;
    logic [RW-1:0]      trial;
    logic               trial_ge;
    logic [RW-1:0]      trial_diff;
    logic               step_last;
    logic               push_done;
    logic [IDX_W-1:0]   pop_idx;
    logic [DW-1:0]      pop_digit;
    logic [VALUE_BITS-1:0] raw;

    assign alphabet = {alpha_second_reg, alpha_first_reg};
    assign accept   = start && (state_reg == srde_pkg::ST_IDLE);
    assign busy     = (state_reg != srde_pkg::ST_IDLE);

    // Radix size out of range
    assign size_bad = (radix_size_reg < srde_pkg::RADIX_MIN) ||
                      (radix_size_reg > RW'(srde_pkg::ALPHABET_MAX));

    // Alphabet check of byte chk_idx against forbidden codes and later bytes
    assign chk_byte = alphabet[8*chk_idx_reg +: 8];
    always_comb
    begin
        dup_hit = 1'b0;
        for (int j = 0; j < srde_pkg::ALPHA_BYTES; j++)
        begin
            if ((RW'(j) > {1'b0, chk_idx_reg}) && (RW'(j) < radix_size_reg) &&
                (alphabet[8*j +: 8] == chk_byte))
            begin
                dup_hit = 1'b1;
            end
        end
    end
    assign chk_bad  = srde_pkg::byte_forbidden(chk_byte) || dup_hit;
    assign chk_last = ({1'b0, chk_idx_reg} == (radix_size_reg - RW'(1)));

    // Restoring division step: one quotient bit per cycle
    assign trial      = {rem_reg, mag_reg[VALUE_BITS-1]};
    assign trial_ge   = (trial >= radix_size_reg);
    assign trial_diff = trial - radix_size_reg;
    assign step_last  = (step_reg == STEP_W'(VALUE_BITS - 1));

    // Digit loop ends on a zero quotient or a full stack
    assign push_done = (mag_reg == '0) || (count_reg == CNT_W'(VALUE_BITS - 1));

    assign raw       = value[VALUE_BITS-1:0];
    assign pop_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign pop_digit = stack_mem[pop_idx];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_size_reg   <= '0;
            alpha_first_reg  <= '0;
            alpha_second_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                srde_pkg::CFG_RADIX_SIZE:   radix_size_reg   <= cfg_data[RW-1:0];
                srde_pkg::CFG_ALPHA_FIRST:  alpha_first_reg  <= cfg_data;
                srde_pkg::CFG_ALPHA_SECOND: alpha_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srde_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = size_bad ? srde_pkg::ST_BAD : srde_pkg::ST_CHECK;
            end
            srde_pkg::ST_CHECK:
            begin
                if (chk_bad)
                    state_next = srde_pkg::ST_BAD;
                else if (chk_last)
                    state_next = srde_pkg::ST_DIVIDE;
            end
            srde_pkg::ST_DIVIDE:
            begin
                if (step_last)
                    state_next = srde_pkg::ST_PUSH;
            end
            srde_pkg::ST_PUSH:
            begin
                if (!push_done)
                    state_next = srde_pkg::ST_DIVIDE;
                else if (neg_reg)
                    state_next = srde_pkg::ST_SIGN;
                else
                    state_next = srde_pkg::ST_EMIT;
            end
            srde_pkg::ST_SIGN:
                state_next = srde_pkg::ST_EMIT;
            srde_pkg::ST_EMIT:
            begin
                if (count_reg == CNT_W'(1))
                    state_next = srde_pkg::ST_IDLE;
            end
            srde_pkg::ST_BAD:
                state_next = srde_pkg::ST_IDLE;
            default:
                state_next = srde_pkg::ST_IDLE;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        mag_next     = mag_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        chk_idx_next = chk_idx_reg;
        neg_next     = neg_reg;
        case (state_reg)
            srde_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next     = raw[VALUE_BITS-1];
                    mag_next     = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
                    chk_idx_next = '0;
                    rem_next     = '0;
                    step_next    = '0;
                    count_next   = '0;
                end
            end
            srde_pkg::ST_CHECK:
                chk_idx_next = chk_idx_reg + DW'(1);
            srde_pkg::ST_DIVIDE:
            begin
                rem_next  = trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
                mag_next  = {mag_reg[VALUE_BITS-2:0], trial_ge};
                step_next = step_reg + STEP_W'(1);
            end
            srde_pkg::ST_PUSH:
            begin
                count_next = count_reg + CNT_W'(1);
                rem_next   = '0;
                step_next  = '0;
            end
            srde_pkg::ST_EMIT:
                count_next = count_reg - CNT_W'(1);
            default: ;
        endcase
    end

    // Result outputs
    always_comb
    begin
        result_strobe = 1'b0;
        character     = srde_pkg::CHAR_NUL;
        last          = 1'b0;
        bad_alphabet  = 1'b0;
        case (state_reg)
            srde_pkg::ST_SIGN:
            begin
                result_strobe = 1'b1;
                character     = srde_pkg::CHAR_MINUS;
            end
            srde_pkg::ST_EMIT:
            begin
                result_strobe = 1'b1;
                character     = alphabet[8*pop_digit +: 8];
                last          = (count_reg == CNT_W'(1));
            end
            srde_pkg::ST_BAD:
            begin
                result_strobe = 1'b1;
                last          = 1'b1;
                bad_alphabet  = 1'b1;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= srde_pkg::ST_IDLE;
            mag_reg     <= '0;
            rem_reg     <= '0;
            step_reg    <= '0;
            count_reg   <= '0;
            chk_idx_reg <= '0;
            neg_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mag_reg     <= mag_next;
            rem_reg     <= rem_next;
            step_reg    <= step_next;
            count_reg   <= count_next;
            chk_idx_reg <= chk_idx_next;
            neg_reg     <= neg_next;
        end
    end

    // Digit stack, least significant digit first
    always_ff @(posedge clk)
    begin
        if (state_reg == srde_pkg::ST_PUSH)
            stack_mem[count_reg[IDX_W-1:0]] <= rem_reg;
    end

endmodule
